>>> rtl/core/cmirq_pkg.sv
// Shared types and constants for the cartridge mapper with A12 interrupt.
// Used by cmirq_map, cmirq_irq and the top level; no dependencies.
`timescale 1ns / 1ps

package cmirq_pkg;

  // PRG ROM size in bytes; a power of two, 65536 to 524288
  localparam int unsigned PrgBytes  = 262144;
  // the A12 low span, in dot_count units, must exceed this to clock the counter
  localparam int unsigned A12LowMin = 9;

  localparam int RomW   = 23;
  localparam int ExromW = 23;
  localparam int BankW  = 6;
  localparam int CycleW = 32;

  // banked PRG addresses are at most 19 bits before wrapping
  localparam logic [18:0] PrgMask      = 19'(PrgBytes - 1);
  localparam logic [BankW-1:0] ChrFixedBank = 6'h3d;

  typedef enum logic [1:0] {
    MODE_CPU_READ  = 2'd0,
    MODE_CPU_WRITE = 2'd1,
    MODE_PPU_ADDR  = 2'd2,
    MODE_DOT_TICK  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    SRC_NONE  = 3'd0,
    SRC_PRG   = 3'd1,
    SRC_EXROM = 3'd2,
    SRC_OPEN  = 3'd3,
    SRC_CHR   = 3'd4
  } src_e;

  // CPU write register, from address bits 14..12
  typedef enum logic [2:0] {
    WR_LATCH      = 3'd0,
    WR_RELOAD     = 3'd1,
    WR_DISABLE    = 3'd2,
    WR_ENABLE     = 3'd3,
    WR_EXROM_SHIFT = 3'd4,
    WR_AUTO_INC   = 3'd5,
    WR_BANK_LO    = 3'd6,
    WR_BANK_HI    = 3'd7
  } wreg_e;

  // bank register select, from data bits 7..6
  typedef enum logic [1:0] {
    BSEL_6000 = 2'd0,
    BSEL_8000 = 2'd1,
    BSEL_A000 = 2'd2,
    BSEL_CHR  = 2'd3
  } bsel_e;

  typedef struct packed {
    mode_e              mode;
    logic [15:0]        cpu_address;
    logic [7:0]         write_data;
    logic [13:0]        ppu_addr;
    logic [CycleW-1:0]  dot_count;
  } item_t;

endpackage

>>> rtl/core/cartridge_mapper_with_a12_irq_unit.sv
// Cartridge mapper with A12 scanline interrupt, top level.
// Each input transfer is held in an input register, then its result in a
// result register; throughput one item per cycle while the output is not
// stalled, set by the single decode/update pass between the two registers.
// Reset clears all mapper and interrupt state and empties both registers. Depends on cmirq_pkg.
`timescale 1ns / 1ps

module cartridge_mapper_with_a12_irq_unit import cmirq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] cpu_address, [23:16] write_data, [37:24] ppu_addr,
  // [69:38] dot_count, [71:70] zero
  input  logic [71:0] s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [22:0] rom_address, [23] irq_raise, [24] irq_clear, [31:25] zero
  output logic [31:0] m_axis_tdata,
  // [2:0] read_source
  output logic [2:0]  m_axis_tuser
);

  logic            in_valid_q;
  item_t           in_item_q;
  logic            out_valid_q;
  src_e            out_src_q;
  logic [RomW-1:0] out_rom_q;
  logic            out_raise_q;
  logic            out_clr_q;

  logic            advance;
  src_e            map_src;
  logic [RomW-1:0] map_rom;
  logic            irq_raise;
  logic            irq_clear;

  // the item in the input register moves on whenever the result slot frees
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.mode        <= mode_e'(s_axis_tuser);
      in_item_q.cpu_address <= s_axis_tdata[15:0];
      in_item_q.write_data  <= s_axis_tdata[23:16];
      in_item_q.ppu_addr    <= s_axis_tdata[37:24];
      in_item_q.dot_count   <= s_axis_tdata[69:38];
    end
  end

  cmirq_map u_map (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .item_i        (in_item_q),
    .read_source_o (map_src),
    .rom_address_o (map_rom)
  );

  cmirq_irq u_irq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .item_i      (in_item_q),
    .irq_raise_o (irq_raise),
    .irq_clear_o (irq_clear)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_src_q   <= map_src;
      out_rom_q   <= map_rom;
      out_raise_q <= irq_raise;
      out_clr_q   <= irq_clear;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_clr_q, out_raise_q, out_rom_q};
  assign m_axis_tuser  = out_src_q;

  a_advance_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> in_valid_q && (!out_valid_q || m_axis_tready))
    else $error("item advanced over an unread result");

endmodule

>>> rtl/core/cmirq_map.sv
// Address mapper: bank registers, EXROM serial pointer and CPU/PPU decode.
// Depends on cmirq_pkg.
`timescale 1ns / 1ps

module cmirq_map import cmirq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  item_t           item_i,
  output src_e            read_source_o,
  output logic [RomW-1:0] rom_address_o
);

  localparam logic [15:0] OpenBase  = 16'h4100;
  localparam logic [15:0] ExromBase = 16'h4800;
  localparam logic [15:0] PrgLoBase = 16'h5000;
  localparam logic [15:0] BankBase  = 16'h6000;
  localparam logic [18:0] PrgLoOffs = 19'h4000;
  localparam logic [BankW-1:0] BankD000 = 6'd3;
  localparam logic [BankW-1:0] BankE000 = 6'd4;

  logic [BankW-1:0]  bank_6000_q, bank_6000_d;
  logic [BankW-1:0]  bank_8000_q, bank_8000_d;
  logic [BankW-1:0]  bank_a000_q, bank_a000_d;
  logic [BankW-1:0]  chr_bank_q, chr_bank_d;
  logic [ExromW-1:0] exrom_ptr_q, exrom_ptr_d;
  logic              auto_inc_q, auto_inc_d;

  logic [BankW-1:0]  prg_bank;
  logic              use_prg;
  logic              fetch;
  logic [15:0]       addr;

  assign addr = item_i.cpu_address;

  always_comb begin
    bank_6000_d   = bank_6000_q;
    bank_8000_d   = bank_8000_q;
    bank_a000_d   = bank_a000_q;
    chr_bank_d    = chr_bank_q;
    exrom_ptr_d   = exrom_ptr_q;
    auto_inc_d    = auto_inc_q;
    read_source_o = SRC_NONE;
    rom_address_o = '0;
    prg_bank      = '0;
    use_prg       = 1'b0;
    fetch         = 1'b0;

    unique case (item_i.mode)
      MODE_CPU_READ: begin
        if (addr >= OpenBase) begin
          priority if (addr < ExromBase) begin
            read_source_o = SRC_OPEN;
          end else if (addr < PrgLoBase) begin
            read_source_o = SRC_EXROM;
            fetch         = 1'b1;
          end else if (addr < BankBase) begin
            read_source_o = SRC_PRG;
            rom_address_o = RomW'((19'(addr) - PrgLoOffs) & PrgMask);
          end else begin
            read_source_o = SRC_PRG;
            use_prg       = 1'b1;
            unique case (addr[15:13])
              3'd3: prg_bank = bank_6000_q;
              3'd4: prg_bank = bank_8000_q;
              3'd5: prg_bank = bank_a000_q;
              3'd6: begin
                if (addr[12]) begin
                  prg_bank = BankD000;
                end else begin
                  read_source_o = SRC_EXROM;
                  use_prg       = 1'b0;
                  fetch         = 1'b1;
                end
              end
              3'd7: prg_bank = BankE000;
              default: use_prg = 1'b0;
            endcase
          end
        end
      end
      MODE_CPU_WRITE: begin
        if (addr[15]) begin
          unique case (wreg_e'(addr[14:12]))
            WR_EXROM_SHIFT: exrom_ptr_d = {exrom_ptr_q[ExromW-2:0], item_i.write_data[7]};
            WR_AUTO_INC:    auto_inc_d  = item_i.write_data[1];
            WR_BANK_LO, WR_BANK_HI: begin
              unique case (bsel_e'(item_i.write_data[7:6]))
                BSEL_6000: bank_6000_d = item_i.write_data[5:0];
                BSEL_8000: bank_8000_d = item_i.write_data[5:0];
                BSEL_A000: bank_a000_d = item_i.write_data[5:0];
                BSEL_CHR:  chr_bank_d  = item_i.write_data[5:0];
                default: ;
              endcase
            end
            default: ;  // interrupt registers live in cmirq_irq
          endcase
        end
      end
      MODE_PPU_ADDR: begin
        if (!item_i.ppu_addr[13]) begin
          read_source_o = SRC_CHR;
          if (item_i.ppu_addr[12]) begin
            rom_address_o = RomW'({ChrFixedBank, item_i.ppu_addr[11:0]});
          end else begin
            rom_address_o = RomW'({chr_bank_q, item_i.ppu_addr[11:0]});
          end
        end
      end
      default: ;
    endcase

    if (use_prg) begin
      rom_address_o = RomW'({prg_bank, addr[12:0]} & PrgMask);
    end
    if (fetch) begin
      rom_address_o = RomW'(exrom_ptr_q);
      if (auto_inc_q) begin
        exrom_ptr_d = exrom_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_6000_q <= '0;
      bank_8000_q <= '0;
      bank_a000_q <= '0;
      chr_bank_q  <= '0;
      exrom_ptr_q <= '0;
      auto_inc_q  <= 1'b0;
    end else if (en_i) begin
      bank_6000_q <= bank_6000_d;
      bank_8000_q <= bank_8000_d;
      bank_a000_q <= bank_a000_d;
      chr_bank_q  <= chr_bank_d;
      exrom_ptr_q <= exrom_ptr_d;
      auto_inc_q  <= auto_inc_d;
    end
  end

  // CHR addresses only come from PPU events
  a_chr_from_ppu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_source_o == SRC_CHR |-> item_i.mode == MODE_PPU_ADDR)
    else $error("CHR source outside a PPU address event");

endmodule

>>> rtl/core/cmirq_irq.sv
// Scanline interrupt: qualified A12 rising-edge filter, 8-bit counter and
// two-tick raise delay. Depends on cmirq_pkg.
`timescale 1ns / 1ps

module cmirq_irq import cmirq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  item_t item_i,
  output logic  irq_raise_o,
  output logic  irq_clear_o
);

  logic [7:0]        counter_q, counter_d;
  logic [7:0]        latch_q, latch_d;
  logic              enabled_q, enabled_d;
  logic              reload_q, reload_d;
  logic [1:0]        delay_q, delay_d;
  logic [CycleW-1:0] low_start_q, low_start_d;
  logic              prev_a12_q, prev_a12_d;
  logic              low_seen_q, low_seen_d;

  logic              cur_a12;
  logic [CycleW-1:0] low_span;
  logic              wr_hit;
  wreg_e             wr_sel;
  logic [7:0]        counter_next;

  assign cur_a12  = item_i.ppu_addr[12];
  assign low_span = item_i.dot_count - low_start_q;  // wraps modulo 2^32
  assign wr_hit   = (item_i.mode == MODE_CPU_WRITE) && item_i.cpu_address[15];
  assign wr_sel   = wreg_e'(item_i.cpu_address[14:12]);
  assign irq_clear_o = wr_hit && (wr_sel == WR_DISABLE);

  // value the counter takes when clocked by a qualified A12 rise
  assign counter_next = (reload_q || counter_q == 8'd0) ? latch_q : counter_q - 8'd1;

  always_comb begin
    counter_d   = counter_q;
    latch_d     = latch_q;
    enabled_d   = enabled_q;
    reload_d    = reload_q;
    delay_d     = delay_q;
    low_start_d = low_start_q;
    prev_a12_d  = prev_a12_q;
    low_seen_d  = low_seen_q;
    irq_raise_o = 1'b0;

    unique case (item_i.mode)
      MODE_CPU_WRITE: begin
        if (wr_hit) begin
          unique case (wr_sel)
            WR_LATCH:   latch_d  = item_i.write_data;
            WR_RELOAD:  reload_d = 1'b1;
            WR_DISABLE: begin
              enabled_d = 1'b0;
              counter_d = '0;
              reload_d  = 1'b0;
              delay_d   = '0;
            end
            WR_ENABLE:  enabled_d = 1'b1;
            default: ;  // mapper registers live in cmirq_map
          endcase
        end
      end
      MODE_PPU_ADDR: begin
        if (!cur_a12 && (prev_a12_q || !low_seen_q)) begin
          low_start_d = item_i.dot_count;
          low_seen_d  = 1'b1;
        end
        if (!prev_a12_q && cur_a12) begin
          if (low_seen_q && low_span > CycleW'(A12LowMin)) begin
            counter_d = counter_next;
            reload_d  = 1'b0;
            if (enabled_q && counter_next == 8'd0) begin
              delay_d = 2'd2;
            end
          end
          low_seen_d = 1'b0;
        end
        prev_a12_d = cur_a12;
      end
      MODE_DOT_TICK: begin
        if (delay_q != 2'd0) begin
          delay_d     = delay_q - 2'd1;
          irq_raise_o = (delay_q == 2'd1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q   <= '0;
      latch_q     <= '0;
      enabled_q   <= 1'b0;
      reload_q    <= 1'b0;
      delay_q     <= '0;
      low_start_q <= '0;
      prev_a12_q  <= 1'b0;
      low_seen_q  <= 1'b0;
    end else if (en_i) begin
      counter_q   <= counter_d;
      latch_q     <= latch_d;
      enabled_q   <= enabled_d;
      reload_q    <= reload_d;
      delay_q     <= delay_d;
      low_start_q <= low_start_d;
      prev_a12_q  <= prev_a12_d;
      low_seen_q  <= low_seen_d;
    end
  end

  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    delay_q != 2'd3)
    else $error("raise delay out of range");

  a_raise_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_raise_o |-> item_i.mode == MODE_DOT_TICK && delay_q == 2'd1)
    else $error("interrupt raised outside a dot tick");

  a_disable_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && irq_clear_o |=> !enabled_q && delay_q == 2'd0 && counter_q == 8'd0)
    else $error("acknowledge write left interrupt state behind");

endmodule
